### rtl/device_address_registry_defines.svh
// Assertion macros for the device address registry.
// Used by the top level; expects clk and arst_n in scope.
`ifndef DEVICE_ADDRESS_REGISTRY_DEFINES_SVH
`define DEVICE_ADDRESS_REGISTRY_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DAR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define DAR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/dar_pkg.sv
// Package for the device address registry: payload types, codes and
// percent/level conversion functions. No dependencies.
package dar_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int ADDR_W          = 64;
	localparam int LEVEL_W         = 8;
	localparam int PCT_W           = 7;
	localparam int PCT_RST         = 100;
	localparam int PCT_MAX         = 100;
	localparam int LEVEL_FULL      = 255;
	localparam int PCT_ROUND       = 50;
	localparam int LEVEL_ROUND     = 127;
	// floor(y/100) == (y*5243) >> 19 for y below 43000
	localparam int RECIP_100       = 5243;
	localparam int RECIP_100_SHIFT = 19;

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_FIND   = 3'd1,
		OP_REMOVE = 3'd2,
		OP_GET    = 3'd3,
		OP_SET    = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_ADDED     = 3'd0,
		ST_OK        = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_NULL      = 3'd4,
		ST_BAD_INDEX = 3'd5
	} status_t;

	typedef struct packed {
		logic [2:0]        opcode;
		logic [ADDR_W-1:0] device_addr;
		logic [3:0]        entry_index;
		logic [7:0]        brightness_pct;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [3:0]         found_index;
		logic [ADDR_W-1:0]  entry_addr;
		logic [LEVEL_W-1:0] entry_level;
		logic [PCT_W-1:0]   entry_pct;
		logic [4:0]         entry_count;
	} rsp_t;

	typedef logic [PCT_W-1:0] cfg_t;

	// table write strobes and data
	typedef struct packed {
		logic               addr_we;
		logic               level_we;
		logic [ADDR_W-1:0]  addr;
		logic [LEVEL_W-1:0] level;
	} tbl_wr_t;

	function automatic logic [PCT_W-1:0] sat_pct(input logic [7:0] p);
		return (p > 8'(PCT_MAX)) ? PCT_W'(PCT_MAX) : p[PCT_W-1:0];
	endfunction

	// (pct*255 + 50) / 100, pct already saturated
	function automatic logic [LEVEL_W-1:0] pct_to_level(input logic [PCT_W-1:0] pct);
		logic [14:0] y;
		logic [27:0] p;
		y = 15'(pct) * 15'(LEVEL_FULL) + 15'(PCT_ROUND);
		p = 28'(y) * 28'(RECIP_100);
		return p[RECIP_100_SHIFT +: LEVEL_W];
	endfunction

	// (level*100 + 127) / 255; x/255 == (x + 1 + (x>>8)) >> 8 for 16-bit x
	function automatic logic [PCT_W-1:0] level_to_pct(input logic [LEVEL_W-1:0] lv);
		logic [15:0] x;
		logic [16:0] s;
		x = 16'(lv) * 16'(PCT_MAX) + 16'(LEVEL_ROUND);
		s = 17'(x) + 17'd1 + 17'(x[15:8]);
		return s[14:8];
	endfunction

endpackage

### rtl/dar_stream_if.sv
// Valid/ready channel carrying one payload type.
// Payload types come from dar_pkg at the instantiating site.
interface dar_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/device_address_registry.sv
// Device address registry: compacting table of device addresses and levels.
// Null-address and bad-index errors go straight to the response; find and add compare
//   the entries in order, get and set read one entry, remove also shifts every entry above it down.
// Throughput: one request at a time, one table entry per cycle through one read port.
// Reset (arst_n low, async): table empty, default percent 100, no response pending.
// Depends on dar_pkg, dar_stream_if, dar_table, dar_ctrl and the defines header.
`include "device_address_registry_defines.svh"

module device_address_registry #(
	parameter int MAX_ENTRIES = dar_pkg::MAX_ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	dar_stream_if.sink   req,
	dar_stream_if.source rsp,
	dar_stream_if.sink   cfg
);
	import dar_pkg::*;

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	// configuration register; the user must write it only while idle, the block itself does not enforce this
	cfg_t default_pct_q;

	// response register: decouples the sequencer from the consumer
	logic rsp_valid_q;
	rsp_t rsp_data_q;

	logic               slot_free;
	logic               res_done;
	rsp_t               result;
	logic [AW-1:0]      raddr;
	logic [AW-1:0]      waddr;
	tbl_wr_t            wr;
	logic [ADDR_W-1:0]  rd_addr;
	logic [LEVEL_W-1:0] rd_level;

	// failure status on the response, and zero index, level and percent fields
	logic rsp_failed;
	logic rsp_no_entry;

	assign cfg.ready = 1'b1;
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_pct_q <= PCT_W'(PCT_RST);
		end else if (cfg.valid) begin
			default_pct_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_done) begin
			rsp_data_q <= result;
		end
	end

	// sequencer: one table access per cycle
	dar_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.AW         (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.req_data   (req.data),
		.default_pct(default_pct_q),
		.slot_free  (slot_free),
		.done       (res_done),
		.result     (result),
		.raddr      (raddr),
		.waddr      (waddr),
		.wr         (wr),
		.rd_addr    (rd_addr),
		.rd_level   (rd_level)
	);

	// entry storage
	dar_table #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.AW         (AW)
	) u_table (
		.clk     (clk),
		.raddr   (raddr),
		.waddr   (waddr),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_level(rd_level)
	);

	assign rsp_failed = rsp.valid && (rsp.data.status == ST_NOT_FOUND ||
		rsp.data.status == ST_FULL || rsp.data.status == ST_NULL ||
		rsp.data.status == ST_BAD_INDEX);
	assign rsp_no_entry = (rsp.data.found_index == '0) && (rsp.data.entry_level == '0) &&
		(rsp.data.entry_pct == '0);

	// a request keeps the sequencer busy, so ready drops once it is taken
	`DAR_ASSERT_NEXT(a_busy_after_req, req.valid && req.ready, !req.ready, "ready held after request")
	// a finished result never overwrites an untaken response
	`DAR_ASSERT_SAME(a_no_overwrite, res_done, !rsp_valid_q || rsp.ready, "response overwritten")
	// failed requests report no entry
	`DAR_ASSERT_SAME(a_fail_zero, rsp_failed, rsp_no_entry, "entry fields set on failure")

endmodule

### rtl/dar_table.sv
// Entry storage: address and level arrays, one write port, one registered
// read port. Uses dar_pkg types.
module dar_table #(
	parameter int MAX_ENTRIES = dar_pkg::MAX_ENTRIES_DEF,
	parameter int AW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
	input  logic                        clk,
	input  logic [AW-1:0]               raddr,
	input  logic [AW-1:0]               waddr,
	input  dar_pkg::tbl_wr_t            wr,
	output logic [dar_pkg::ADDR_W-1:0]  rd_addr,
	output logic [dar_pkg::LEVEL_W-1:0] rd_level
);
	import dar_pkg::*;

	logic [ADDR_W-1:0]  addr_mem  [MAX_ENTRIES];
	logic [LEVEL_W-1:0] level_mem [MAX_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.addr_we) begin
			addr_mem[waddr] <= wr.addr;
		end
		if (wr.level_we) begin
			level_mem[waddr] <= wr.level;
		end
		rd_addr  <= addr_mem[raddr];
		rd_level <= level_mem[raddr];
	end

endmodule

### rtl/dar_ctrl.sv
// Sequencer of the registry: scans, shifts and updates the table one entry
// per cycle through a single comparator. Uses dar_pkg.
module dar_ctrl #(
	parameter int MAX_ENTRIES = dar_pkg::MAX_ENTRIES_DEF,
	parameter int AW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  dar_pkg::req_t               req_data,
	input  dar_pkg::cfg_t               default_pct,
	input  logic                        slot_free,
	output logic                        done,
	output dar_pkg::rsp_t               result,
	output logic [AW-1:0]               raddr,
	output logic [AW-1:0]               waddr,
	output dar_pkg::tbl_wr_t            wr,
	input  logic [dar_pkg::ADDR_W-1:0]  rd_addr,
	input  logic [dar_pkg::LEVEL_W-1:0] rd_level
);
	import dar_pkg::*;

	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int CMPW = (CW > 4) ? CW : 4;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_PREP  = 8'b0000_0010,
		S_SCAN  = 8'b0000_0100,
		S_READ  = 8'b0000_1000,
		S_CAPT  = 8'b0001_0000,
		S_SHIFT = 8'b0010_0000,
		S_CONV  = 8'b0100_0000,
		S_FIN   = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [2:0]         op_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [3:0]         idx_q;
	logic [PCT_W-1:0]   pct_q;
	logic [LEVEL_W-1:0] level_new_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      rd_ptr_q;
	logic               cmp_vld_q;
	logic [AW-1:0]      cmp_idx_q;
	logic               sh_vld_q;
	logic [AW-1:0]      sh_wr_q;
	rsp_t               res_q;

	logic          match;
	logic          more;
	logic          full;
	logic          idx_ok;
	logic [CW-1:0] idx_cw;
	logic          add_wr;
	status_t       prep_status;

	assign idx_cw = CW'(idx_q);
	assign idx_ok = CMPW'(idx_q) < CMPW'(count_q);
	assign match  = cmp_vld_q && (rd_addr == addr_q);
	assign more   = rd_ptr_q < count_q;
	assign full   = count_q == CW'(MAX_ENTRIES);
	// append on a miss at the end of an add scan, unless the table is full
	assign add_wr = (state_q == S_SCAN) && !match && !more && (op_q == OP_ADD) && !full;
	// status preset in PREP: null address on an add, bad index otherwise
	assign prep_status = ((op_q == OP_ADD) && (addr_q == '0)) ? ST_NULL : ST_BAD_INDEX;

	assign req_ready = (state_q == S_IDLE);
	assign done      = (state_q == S_FIN) && slot_free;

	always_comb begin
		result             = res_q;
		result.entry_count = 5'(count_q);
	end

	// table port steering
	always_comb begin
		raddr = rd_ptr_q[AW-1:0];
		waddr = '0;
		wr    = '0;
		if (state_q == S_READ) begin
			raddr = idx_cw[AW-1:0];
			if (op_q == OP_SET) begin
				waddr       = idx_cw[AW-1:0];
				wr.level_we = 1'b1;
				wr.level    = level_new_q;
			end
		end else if (add_wr) begin
			waddr       = count_q[AW-1:0];
			wr.addr_we  = 1'b1;
			wr.level_we = 1'b1;
			wr.addr     = addr_q;
			wr.level    = level_new_q;
		end else if ((state_q == S_SHIFT) && sh_vld_q) begin
			waddr       = sh_wr_q;
			wr.addr_we  = 1'b1;
			wr.level_we = 1'b1;
			wr.addr     = rd_addr;
			wr.level    = rd_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			cmp_vld_q <= 1'b0;
			sh_vld_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q   <= req_data.opcode;
						addr_q <= req_data.device_addr;
						idx_q  <= req_data.entry_index;
						pct_q  <= (req_data.opcode == OP_SET) ?
							sat_pct(req_data.brightness_pct) : sat_pct({1'b0, default_pct});
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					level_new_q <= pct_to_level(pct_q);
					res_q       <= '{status: prep_status, default: '0};
					rd_ptr_q    <= '0;
					cmp_vld_q   <= 1'b0;
					sh_vld_q    <= 1'b0;
					unique case (op_q)
						OP_ADD: begin
							if (addr_q == '0) begin
								state_q <= S_FIN;
							end else begin
								state_q <= S_SCAN;
							end
						end
						OP_FIND: state_q <= S_SCAN;
						OP_REMOVE, OP_GET, OP_SET: state_q <= idx_ok ? S_READ : S_FIN;
						default: state_q <= S_FIN;
					endcase
				end
				S_SCAN: begin
					// read of entry i overlaps the compare of entry i-1
					if (match) begin
						res_q.status      <= ST_OK;
						res_q.found_index <= 4'(cmp_idx_q);
						res_q.entry_addr  <= rd_addr;
						res_q.entry_level <= rd_level;
						cmp_vld_q         <= 1'b0;
						state_q           <= S_CONV;
					end else if (more) begin
						rd_ptr_q  <= rd_ptr_q + 1'b1;
						cmp_vld_q <= 1'b1;
						cmp_idx_q <= rd_ptr_q[AW-1:0];
					end else begin
						cmp_vld_q <= 1'b0;
						if (op_q != OP_ADD) begin
							res_q.status <= ST_NOT_FOUND;
							state_q      <= S_FIN;
						end else if (full) begin
							res_q.status <= ST_FULL;
							state_q      <= S_FIN;
						end else begin
							res_q.status      <= ST_ADDED;
							res_q.found_index <= 4'(count_q);
							res_q.entry_addr  <= addr_q;
							res_q.entry_level <= level_new_q;
							count_q           <= count_q + 1'b1;
							state_q           <= S_CONV;
						end
					end
				end
				S_READ: begin
					rd_ptr_q <= idx_cw + 1'b1;
					state_q  <= S_CAPT;
				end
				S_CAPT: begin
					res_q.status      <= ST_OK;
					res_q.found_index <= idx_q;
					res_q.entry_addr  <= rd_addr;
					res_q.entry_level <= (op_q == OP_SET) ? level_new_q : rd_level;
					state_q           <= (op_q == OP_REMOVE) ? S_SHIFT : S_CONV;
				end
				S_SHIFT: begin
					// read entry i+2 while writing entry i+1, fetched last cycle, down to i
					if (more) begin
						rd_ptr_q <= rd_ptr_q + 1'b1;
						sh_vld_q <= 1'b1;
						sh_wr_q  <= AW'(rd_ptr_q - 1'b1);
					end else begin
						sh_vld_q <= 1'b0;
						count_q  <= count_q - 1'b1;
						state_q  <= S_CONV;
					end
				end
				S_CONV: begin
					res_q.entry_pct <= level_to_pct(res_q.entry_level);
					state_q         <= S_FIN;
				end
				S_FIN: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
